// ----- sv/idq_pkg.sv -----
// ----------------------------------------------------------------------------
// idq_pkg - shared definitions for the indexed double-ended queue
// Sizes, opcode and state codes, and the pending-response record.
// ----------------------------------------------------------------------------
package idq_pkg;

  // Ring store depth; slot arithmetic wraps by truncation, so a power of two.
  localparam int CAPACITY = 256;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = PTR_W + 1;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 16;

  // Beat layouts
  localparam int IN_TDATA_W  = ((DATA_W + POS_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = DATA_W + CNT_W + DATA_W + DATA_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OP_W        = 3;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_PREPEND   = 3'd1,
    OP_POP_BACK  = 3'd2,
    OP_POP_FRONT = 3'd3,
    OP_READ      = 3'd4,
    OP_WRITE     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RSP  = 2'b10
  } state_t;

  // What the response cycle takes from the memory read port
  typedef struct packed {
    logic ok;
    logic rd_sel;
    logic front_sel;
    logic back_sel;
  } pend_t;

endpackage

// ----- sv/indexed_double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// indexed_double_ended_queue - bounded deque of signed 32-bit values
// Ring store in one synchronous RAM, located by a front pointer and a count.
//
// Input stream: in_tuser carries the opcode (append, prepend, remove last,
// remove first, read at index, write at index); in_tdata carries the value
// and the index. Every input beat gives exactly one result beat on the out_
// stream: read value, ok flag in out_tuser, count, front and back values.
//
// Ordering: an accepted beat moves to the response state; its result enters
// the output register once the registered read of the slot RAM is back and
// the output register is free. No new beat is taken until then (each
// operation reads at most one slot, whose data is used in the response cycle
// to fill the result and the cached front and back values).
//
// Reset empties the queue at once (front pointer and count cleared); the RAM
// itself is not cleared, only written slots are ever read. A stalled
// receiver holds the result in the output register; the next input beat is
// still taken, and its response waits until the output register frees up.
// ----------------------------------------------------------------------------
module indexed_double_ended_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] item_value, [47:32] position
  input  logic [idq_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [2:0] opcode
  input  logic [idq_pkg::OP_W-1:0]           in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] read_value, [40:32] entry_count, [72:41] front_value,
  // [104:73] back_value, upper bits zero
  output logic [idq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] ok
  output logic                               out_tuser
);
  import idq_pkg::*;

  logic [DATA_W-1:0] slot_mem [CAPACITY];

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   fp_r, fp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DATA_W-1:0]  front_r, front_nxt;
  logic [DATA_W-1:0]  back_r, back_nxt;
  pend_t              pend_r, pend_nxt;
  logic [DATA_W-1:0]  rd_data_r;
  logic               out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic               out_ok_r;

  logic               in_fire;
  logic               rsp_load;
  logic [OP_W-1:0]    op;
  logic [DATA_W-1:0]  in_val;
  logic [POS_W-1:0]   in_pos;
  logic               full, empty, pos_ok;
  logic [PTR_W-1:0]   pos_idx;
  logic [PTR_W-1:0]   last_off;

  logic               we, re;
  logic [PTR_W-1:0]   waddr, raddr;

  logic [DATA_W-1:0]  rsp_front, rsp_back, rsp_rd;

  assign op      = in_tuser;
  assign in_val  = in_tdata[DATA_W-1:0];
  assign in_pos  = in_tdata[DATA_W+POS_W-1:DATA_W];
  assign pos_idx = in_pos[PTR_W-1:0];
  assign full    = (cnt_r == CAP_CNT);
  assign empty   = (cnt_r == '0);
  assign pos_ok  = !in_pos[POS_W-1] &&
                   ((POS_W-1)'(cnt_r) > in_pos[POS_W-2:0]);
  assign last_off = PTR_W'(cnt_r - CNT_W'(1));

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign rsp_load  = (state_r == ST_RSP) && (!out_valid_r || out_tready);

  // Accept-cycle decode: pointer/count update, RAM access, pending record; response cycle: back to idle, load the ends
  always_comb begin
    fp_nxt   = fp_r;
    cnt_nxt  = cnt_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    pend_nxt = pend_r;
    state_nxt = state_r;
    we    = 1'b0;
    re    = 1'b0;
    waddr = fp_r;
    raddr = fp_r;

    if (in_fire) begin
      state_nxt = ST_RSP;
      pend_nxt  = '0;
      case (op)
        OP_APPEND: begin
          if (!full) begin
            we       = 1'b1;
            waddr    = fp_r + PTR_W'(cnt_r);
            cnt_nxt  = cnt_r + CNT_W'(1);
            back_nxt = in_val;
            if (empty) front_nxt = in_val;
            pend_nxt.ok = 1'b1;
          end
        end
        OP_PREPEND: begin
          if (!full) begin
            we        = 1'b1;
            waddr     = fp_r - PTR_W'(1);
            fp_nxt    = fp_r - PTR_W'(1);
            cnt_nxt   = cnt_r + CNT_W'(1);
            front_nxt = in_val;
            if (empty) back_nxt = in_val;
            pend_nxt.ok = 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (!empty) begin
            // new back is two slots short of fp + count
            re      = 1'b1;
            raddr   = fp_r + PTR_W'(cnt_r) - PTR_W'(2);
            cnt_nxt = cnt_r - CNT_W'(1);
            pend_nxt.ok       = 1'b1;
            pend_nxt.back_sel = 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (!empty) begin
            re      = 1'b1;
            raddr   = fp_r + PTR_W'(1);
            fp_nxt  = fp_r + PTR_W'(1);
            cnt_nxt = cnt_r - CNT_W'(1);
            pend_nxt.ok        = 1'b1;
            pend_nxt.front_sel = 1'b1;
          end
        end
        OP_READ: begin
          if (pos_ok) begin
            re    = 1'b1;
            raddr = fp_r + pos_idx;
            pend_nxt.ok     = 1'b1;
            pend_nxt.rd_sel = 1'b1;
          end
        end
        OP_WRITE: begin
          if (pos_ok) begin
            we    = 1'b1;
            waddr = fp_r + pos_idx;
            if (pos_idx == '0) front_nxt = in_val;
            if (pos_idx == last_off) back_nxt = in_val;
            pend_nxt.ok = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (rsp_load) begin
      state_nxt = ST_IDLE;
      front_nxt = rsp_front;
      back_nxt  = rsp_back;
    end
  end

  // Response cycle: merge RAM read data into the cached ends and the read result; ends read zero when empty
  always_comb begin
    rsp_front = pend_r.front_sel ? rd_data_r : front_r;
    rsp_back  = pend_r.back_sel  ? rd_data_r : back_r;
    rsp_rd    = pend_r.rd_sel    ? rd_data_r : '0;
    if (cnt_r == '0) begin
      rsp_front = '0;
      rsp_back  = '0;
    end
  end

  // Slot RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) slot_mem[waddr] <= in_val;
    if (re) rd_data_r <= slot_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fp_r        <= '0;
      cnt_r       <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fp_r    <= fp_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      if (rsp_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
    back_r  <= back_nxt;
    if (rsp_load) begin
      out_data_r <= OUT_TDATA_W'({rsp_back, rsp_front, cnt_r, rsp_rd});
      out_ok_r   <= pend_r.ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_accept_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_RSP))
    else $error("accepted beat did not enter response cycle");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && empty && (op == OP_POP_BACK || op == OP_POP_FRONT)
      |=> !pend_r.ok && (cnt_r == '0))
    else $error("remove on empty queue reported success");

  a_ends_need_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RSP) && pend_r.front_sel |-> pend_r.ok && !pend_r.rd_sel)
    else $error("front refill without a successful remove");

endmodule
